/* rtl/plucked_string_voice_macros.svh */
// Assertion macros shared by the plucked string voice RTL.
`ifndef PLUCKED_STRING_VOICE_MACROS_SVH
`define PLUCKED_STRING_VOICE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PSV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PSV_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/psv_pkg.sv */
// Shared constants, types and saturation helper for the plucked string voice.
package psv_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TABLE_DEPTH = 65536;
    localparam int MAX_DELAY   = 4096;

    localparam int LEN_CAP = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
    localparam int POS_W   = $clog2(LEN_CAP);
    localparam int LEN_W   = POS_W + 1;
    localparam int DELAY_W = $clog2(MAX_DELAY);
    localparam int FILL_W  = DELAY_W + 1;
    localparam int IDX_W   = ((POS_W > DELAY_W) ? POS_W : DELAY_W) + 2;
    localparam int XW      = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int PW      = XW + 18;
    localparam int WIDE_W  = PW + 1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_DELAY   = 3'd0;
    localparam logic [2:0] REG_ALLPASS = 3'd1;
    localparam logic [2:0] REG_GAIN    = 3'd2;
    localparam logic [2:0] REG_LOWPASS = 3'd3;
    localparam logic [2:0] REG_LENGTH  = 3'd4;

    localparam logic [11:0] RST_DELAY   = 12'd100;
    localparam logic [15:0] RST_ALLPASS = 16'd32768;
    localparam logic [15:0] RST_GAIN    = 16'd32440;
    localparam logic [15:0] RST_LOWPASS = 16'd16384;
    localparam logic [16:0] RST_LENGTH  = 17'd65536;

    localparam logic [15:0] COEF_ONE = 16'h8000;

    localparam logic OP_PLUCK = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [WIDE_W-1:0]      t_wide;

    localparam t_wide RND15   = WIDE_W'(16384);
    localparam t_wide RND16   = WIDE_W'(32768);
    localparam t_wide SAT_MAX = WIDE_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam t_wide SAT_MIN = WIDE_W'(-(1 << (SAMPLE_BITS - 1)));

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [15:0]        allpass_coef;
        logic [15:0]        loop_gain;
        logic [15:0]        lowpass_coef;
        logic [LEN_W-1:0]   len;
    } t_cfg;

    function automatic t_sample sat_sample(input t_wide x);
        t_sample r;
        if (x > SAT_MAX) begin
            r = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (x < SAT_MIN) begin
            r = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            r = x[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/psv_in_if.sv */
// Input channel carrying pluck and tick transactions.
interface psv_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] noise_sample;

    modport source (output valid, output op, output noise_sample, input ready);
    modport sink   (input valid, input op, input noise_sample, output ready);
endinterface

/* rtl/psv_out_if.sv */
// Output channel carrying audio sample transactions.
interface psv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] audio_sample;
    logic [15:0]        play_index;

    modport source (output valid, output audio_sample, output play_index, input ready);
    modport sink   (input valid, input audio_sample, input play_index, output ready);
endinterface

/* rtl/psv_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module psv_ram #(
    parameter int W_BITS = 16,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W_BITS-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W_BITS-1:0]        o_rdata
);
    logic [W_BITS-1:0] r_mem [DEPTH];
    logic [W_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/psv_cfg.sv */
// APB configuration registers with range clamping for the plucked string voice.
module psv_cfg
    import psv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    logic [11:0] r_delay;
    logic [15:0] r_apc;
    logic [15:0] r_gain;
    logic [15:0] r_lpc;
    logic [16:0] r_len;
    logic        w_wr;
    logic [31:0] w_dl;
    logic [31:0] w_ln;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= RST_DELAY;
            r_apc   <= RST_ALLPASS;
            r_gain  <= RST_GAIN;
            r_lpc   <= RST_LOWPASS;
            r_len   <= RST_LENGTH;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_DELAY:   r_delay <= pwdata[11:0];
                REG_ALLPASS: r_apc   <= pwdata[15:0];
                REG_GAIN:    r_gain  <= pwdata[15:0];
                REG_LOWPASS: r_lpc   <= pwdata[15:0];
                REG_LENGTH:  r_len   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DELAY:   prdata = {20'b0, r_delay};
            REG_ALLPASS: prdata = {16'b0, r_apc};
            REG_GAIN:    prdata = {16'b0, r_gain};
            REG_LOWPASS: prdata = {16'b0, r_lpc};
            REG_LENGTH:  prdata = {15'b0, r_len};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        w_dl = {20'b0, r_delay};
        if (w_dl < 32'd1) begin
            w_dl = 32'd1;
        end else if (w_dl > 32'(MAX_DELAY - 1)) begin
            w_dl = 32'(MAX_DELAY - 1);
        end
        w_ln = {15'b0, r_len};
        if (w_ln < 32'd2) begin
            w_ln = 32'd2;
        end else if (w_ln > 32'(LEN_CAP)) begin
            w_ln = 32'(LEN_CAP);
        end
        o_cfg.delay        = DELAY_W'(w_dl);
        o_cfg.allpass_coef = (r_apc > COEF_ONE) ? COEF_ONE : r_apc;
        o_cfg.loop_gain    = r_gain;
        o_cfg.lowpass_coef = (r_lpc > COEF_ONE) ? COEF_ONE : r_lpc;
        o_cfg.len          = LEN_W'(w_ln);
    end
endmodule

/* rtl/plucked_string_voice.sv */
// Plucked string voice top level: control FSM, string datapath and tone table RAM.
// Pluck: at most one RAM write, no result. Tick replaying a stored entry: read in S_TICK, data
// captured in S_RDDATA, result registered in S_EMIT. Tick computing a new entry: two tap reads
// on the one RAM read port, two chained multiplies; states S_TAP0, S_TAP1, S_MUL1, S_MUL2, S_WB,
// S_EMIT; S_EMIT waits while the output is stalled. Synchronous reset clears note state, sets
// configuration to defaults, leaves the tone table; transactions are taken from the next cycle.
`include "plucked_string_voice_macros.svh"

module plucked_string_voice
    import psv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    psv_in_if.sink            i_in,
    psv_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PLUCK  = 4'd1;
    localparam logic [3:0] S_TICK   = 4'd2;
    localparam logic [3:0] S_TAP0   = 4'd3;
    localparam logic [3:0] S_TAP1   = 4'd4;
    localparam logic [3:0] S_MUL1   = 4'd5;
    localparam logic [3:0] S_MUL2   = 4'd6;
    localparam logic [3:0] S_WB     = 4'd7;
    localparam logic [3:0] S_RDDATA = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    t_cfg w_cfg;

    logic [3:0]         r_state, n_state;
    logic signed [15:0] r_noise, n_noise;
    logic [FILL_W-1:0]  r_fill, n_fill;
    t_sample            r_lp, n_lp;
    t_sample            r_ap, n_ap;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_gen, n_gen;
    logic               r_open, n_open;
    logic [POS_W-1:0]   r_pcur, n_pcur;
    t_sample            r_a0, n_a0;
    t_sample            r_a1, n_a1;
    logic               r_tap0_neg, n_tap0_neg;
    logic               r_tap1_neg, n_tap1_neg;
    t_wide              r_prod, n_prod;
    t_sample            r_y, n_y;
    t_sample            r_sample, n_sample;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_sample, n_out_sample;
    logic [15:0]        r_out_index, n_out_index;

    logic                   w_we;
    logic [POS_W-1:0]       w_waddr;
    t_sample                w_wdata;
    logic                   w_re;
    logic [POS_W-1:0]       w_raddr;
    logic [SAMPLE_BITS-1:0] w_rdata;

    logic [FILL_W-1:0]       w_fill_eff;
    t_sample                 w_lp_src;
    logic                    w_fill_ok;
    logic signed [XW-1:0]    w_v;
    logic signed [XW-1:0]    w_lpx;
    logic signed [XW:0]      w_lpd;
    logic signed [16:0]      w_lpc;
    logic signed [PW-1:0]    w_lpp;
    t_wide                   w_lps;
    t_sample                 w_x;

    logic signed [SAMPLE_BITS:0] w_apd;
    logic signed [16:0]          w_apc;
    logic signed [PW-1:0]        w_app;
    t_wide                       w_ys;
    t_sample                     w_y;
    logic signed [SAMPLE_BITS:0] w_gs;
    logic signed [16:0]          w_gc;
    logic signed [PW-1:0]        w_gp;
    t_sample                     w_s;

    logic [POS_W-1:0] w_pcur_tick;
    logic [LEN_W-1:0] w_gen_next;
    logic [IDX_W-1:0] w_idx0;
    logic [IDX_W-1:0] w_idx1;
    logic             w_need_gen;

    psv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    psv_ram #(
        .W_BITS (SAMPLE_BITS),
        .DEPTH  (LEN_CAP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.audio_sample = r_out_sample;
    assign o_out.play_index   = r_out_index;

    // Lowpass on the noise burst: x = v + a*(lp - v), rounded half up.
    assign w_fill_eff = r_open ? '0 : r_fill;
    assign w_lp_src   = r_open ? '0 : r_lp;
    assign w_fill_ok  = (w_fill_eff <= FILL_W'(w_cfg.delay))
                     && (32'(w_fill_eff) < 32'(LEN_CAP));
    assign w_v        = XW'(r_noise);
    assign w_lpx      = XW'(w_lp_src);
    assign w_lpd      = (XW + 1)'(w_lpx) - (XW + 1)'(w_v);
    assign w_lpc      = {1'b0, w_cfg.lowpass_coef};
    assign w_lpp      = w_lpc * w_lpd;
    assign w_lps      = (WIDE_W'(w_v) <<< 15) + WIDE_W'(w_lpp) + RND15;
    assign w_x        = sat_sample(w_lps >>> 15);

    // Allpass tuner and loop gain.
    assign w_apd = (SAMPLE_BITS + 1)'(r_a0) - (SAMPLE_BITS + 1)'(r_ap);
    assign w_apc = {1'b0, w_cfg.allpass_coef};
    assign w_app = w_apc * w_apd;
    assign w_ys  = ((r_prod + RND15) >>> 15) + WIDE_W'(r_a1);
    assign w_y   = sat_sample(w_ys);
    assign w_gs  = (SAMPLE_BITS + 1)'(w_y) + (SAMPLE_BITS + 1)'(r_ap);
    assign w_gc  = {1'b0, w_cfg.loop_gain};
    assign w_gp  = w_gc * w_gs;
    assign w_s   = sat_sample((r_prod + RND16) >>> 16);

    assign w_pcur_tick = ({1'b0, r_pos} >= w_cfg.len) ? '0 : r_pos;
    assign w_gen_next  = {1'b0, r_pcur} + LEN_W'(1);
    assign w_idx0      = IDX_W'(r_pcur) - IDX_W'(w_cfg.delay);
    assign w_idx1      = w_idx0 - IDX_W'(1);
    assign w_need_gen  = ({1'b0, w_pcur_tick} >= r_gen);

    always_comb begin
        n_state      = r_state;
        n_noise      = r_noise;
        n_fill       = r_fill;
        n_lp         = r_lp;
        n_ap         = r_ap;
        n_pos        = r_pos;
        n_gen        = r_gen;
        n_open       = r_open;
        n_pcur       = r_pcur;
        n_a0         = r_a0;
        n_a1         = r_a1;
        n_tap0_neg   = r_tap0_neg;
        n_tap1_neg   = r_tap1_neg;
        n_prod       = r_prod;
        n_y          = r_y;
        n_sample     = r_sample;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_index  = r_out_index;
        w_we         = 1'b0;
        w_waddr      = r_pcur;
        w_wdata      = w_s;
        w_re         = 1'b0;
        w_raddr      = r_pcur;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_noise = i_in.noise_sample;
                    n_state = (i_in.op == OP_TICK) ? S_TICK : S_PLUCK;
                end
            end
            S_PLUCK: begin
                if (r_open) begin
                    n_ap   = '0;
                    n_pos  = '0;
                    n_gen  = '0;
                    n_open = 1'b0;
                end
                n_fill = w_fill_eff;
                n_lp   = w_lp_src;
                if (w_fill_ok) begin
                    w_we    = 1'b1;
                    w_waddr = POS_W'(w_fill_eff);
                    w_wdata = w_x;
                    n_lp    = w_x;
                    n_fill  = w_fill_eff + FILL_W'(1);
                end
                n_state = S_IDLE;
            end
            S_TICK: begin
                n_open = 1'b1;
                n_pcur = w_pcur_tick;
                if (w_need_gen && (32'(w_pcur_tick) >= 32'(r_fill))) begin
                    n_state = S_TAP0;
                end else begin
                    if (w_need_gen) begin
                        n_gen = {1'b0, w_pcur_tick} + LEN_W'(1);
                    end
                    w_re    = 1'b1;
                    w_raddr = w_pcur_tick;
                    n_state = S_RDDATA;
                end
            end
            S_TAP0: begin
                w_re       = 1'b1;
                w_raddr    = POS_W'(w_idx0);
                n_tap0_neg = w_idx0[IDX_W-1];
                n_state    = S_TAP1;
            end
            S_TAP1: begin
                n_a0       = r_tap0_neg ? '0 : w_rdata;
                w_re       = 1'b1;
                w_raddr    = POS_W'(w_idx1);
                n_tap1_neg = w_idx1[IDX_W-1];
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                n_a1    = r_tap1_neg ? '0 : w_rdata;
                n_prod  = WIDE_W'(w_app);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_y     = w_y;
                n_prod  = WIDE_W'(w_gp);
                n_state = S_WB;
            end
            S_WB: begin
                w_we     = 1'b1;
                w_waddr  = r_pcur;
                w_wdata  = w_s;
                n_ap     = r_y;
                n_gen    = w_gen_next;
                n_sample = w_s;
                n_state  = S_EMIT;
            end
            S_RDDATA: begin
                n_sample = w_rdata;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = 16'(r_sample);
                    n_out_index  = 16'(r_pcur);
                    n_pos        = (w_gen_next >= w_cfg.len) ? '0 : POS_W'(w_gen_next);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_lp        <= '0;
            r_ap        <= '0;
            r_pos       <= '0;
            r_gen       <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_lp        <= n_lp;
            r_ap        <= n_ap;
            r_pos       <= n_pos;
            r_gen       <= n_gen;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_noise      <= n_noise;
        r_pcur       <= n_pcur;
        r_a0         <= n_a0;
        r_a1         <= n_a1;
        r_tap0_neg   <= n_tap0_neg;
        r_tap1_neg   <= n_tap1_neg;
        r_prod       <= n_prod;
        r_y          <= n_y;
        r_sample     <= n_sample;
        r_out_sample <= n_out_sample;
        r_out_index  <= n_out_index;
    end

    `PSV_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state != S_IDLE), "accepted transaction did not start work")
    `PSV_ASSERT(a_write_states, i_clk, i_rst_n, w_we |-> (r_state == S_PLUCK || r_state == S_WB), "table write outside pluck or writeback")
    `PSV_ASSERT(a_gen_after_wb, i_clk, i_rst_n, (r_state == S_WB) |=> (r_gen == $past(w_gen_next)), "generated count not advanced past new entry")
    `PSV_ASSERT(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_EMIT), "result loaded outside emit")
    `PSV_ASSERT_NORST(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && r_state == S_IDLE), "reset left result or work pending")
endmodule

/* verif/psv_tb_pkg.sv */
// Scoreboard class: tracks plucked string note state and checks emitted samples.
`timescale 1ns / 100ps
package psv_tb_pkg;
    import psv_pkg::*;

    typedef struct {
        logic signed [15:0] audio;
        logic [15:0]        index;
    } voice_sample_t;

    class voice_tracker;
        bit signed [15:0] tone [TABLE_DEPTH];
        int               fill_cnt;
        int               gen_cnt;
        int               play_pos;
        longint           lowpass_mem;
        longint           allpass_mem;
        bit               note_live;
        logic [11:0]      delay_reg;
        logic [15:0]      allpass_reg;
        logic [15:0]      gain_reg;
        logic [15:0]      lowpass_reg;
        logic [16:0]      length_reg;
        voice_sample_t    sample_queue[$];
        int               errors;

        function void clear_note();
            fill_cnt    = 0;
            gen_cnt     = 0;
            play_pos    = 0;
            lowpass_mem = 0;
            allpass_mem = 0;
            note_live   = 1'b0;
        endfunction

        function void power_on();
            foreach (tone[i]) tone[i] = '0;
            clear_note();
            sample_queue.delete();
            errors      = 0;
            delay_reg   = RST_DELAY;
            allpass_reg = RST_ALLPASS;
            gain_reg    = RST_GAIN;
            lowpass_reg = RST_LOWPASS;
            length_reg  = RST_LENGTH;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_DELAY:   delay_reg   = value[11:0];
                REG_ALLPASS: allpass_reg = value[15:0];
                REG_GAIN:    gain_reg    = value[15:0];
                REG_LOWPASS: lowpass_reg = value[15:0];
                REG_LENGTH:  length_reg  = value[16:0];
                default: ;
            endcase
        endfunction

        function longint round_half_up(input longint x, input int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function logic signed [15:0] clip(input longint x);
            if (x > 32767) return 16'sh7FFF;
            if (x < -32768) return 16'sh8000;
            return x[15:0];
        endfunction

        function longint q15_clamp(input logic [15:0] c);
            return (c > COEF_ONE) ? longint'(COEF_ONE) : longint'(c);
        endfunction

        function longint tap(input longint idx);
            if (idx < 0 || idx >= TABLE_DEPTH) return 0;
            return longint'(tone[int'(idx)]);
        endfunction

        // Returns 0 for a pluck that the voice ignores.
        function bit take_item(input logic op, input logic signed [15:0] noise);
            int                 n;
            int                 len;
            int                 p;
            longint             a;
            longint             c;
            longint             a0;
            longint             a1;
            logic signed [15:0] x;
            logic signed [15:0] y;
            logic signed [15:0] s;
            voice_sample_t      want;
            n = (delay_reg < 1) ? 1 : int'(delay_reg);
            if (n > MAX_DELAY - 1) n = MAX_DELAY - 1;
            if (op == OP_PLUCK) begin
                a = q15_clamp(lowpass_reg);
                if (note_live) clear_note();
                if (fill_cnt < n + 1 && fill_cnt < TABLE_DEPTH) begin
                    x = clip(round_half_up((32768 - a) * longint'(noise) + a * lowpass_mem, 15));
                    tone[fill_cnt] = x;
                    lowpass_mem = x;
                    fill_cnt++;
                    return 1'b1;
                end
                return 1'b0;
            end
            len = int'(length_reg);
            if (len < 2) len = 2;
            if (len > LEN_CAP) len = LEN_CAP;
            p = play_pos;
            note_live = 1'b1;
            if (p >= len) p = 0;
            if (p >= gen_cnt) begin
                if (p >= fill_cnt) begin
                    c  = q15_clamp(allpass_reg);
                    a0 = tap(p - n);
                    a1 = tap(p - n - 1);
                    y  = clip(round_half_up(c * (a0 - allpass_mem), 15) + a1);
                    s  = clip(round_half_up(longint'(gain_reg) * (longint'(y) + allpass_mem), 16));
                    tone[p] = s;
                    allpass_mem = y;
                end
                gen_cnt = p + 1;
            end
            want.audio = tone[p];
            want.index = 16'(p);
            sample_queue.push_back(want);
            p++;
            if (p >= len) p = 0;
            play_pos = p;
            return 1'b1;
        endfunction

        function void flag(input string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_sample(input logic signed [15:0] audio, input logic [15:0] index);
            voice_sample_t want;
            if (sample_queue.size() == 0) begin
                flag($sformatf("unexpected sample: audio %0d index %0d", audio, index));
                return;
            end
            want = sample_queue.pop_front();
            if (audio !== want.audio || index !== want.index)
                flag($sformatf("sample mismatch: expected audio %0d index %0d, got audio %0d index %0d",
                               want.audio, want.index, audio, index));
        endfunction
    endclass

endpackage

/* verif/tb.sv */
// Testbench top: drives pluck and tick transactions and checks every emitted sample.
`timescale 1ns / 100ps
module tb;
    import psv_pkg::*;
    import psv_tb_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 1250;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    psv_in_if  in_ch ();
    psv_out_if out_ch ();

    plucked_string_voice dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    voice_tracker board;
    bit           src_calm;
    bit           snk_calm;
    int           hold_request = 0;
    int           counted = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic logic signed [15:0] noise_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] coef_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_ONE;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [15:0] noise);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.noise_sample <= noise;
        do @(posedge i_clk); while (!in_ch.ready);
        if (board.take_item(op, noise)) counted++;
    endtask

    // Drop valid, drain every expected sample, then let the pipeline go quiet.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (board.sample_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [31:0] delay, input logic [31:0] allpass,
                                  input logic [31:0] gain, input logic [31:0] lowpass,
                                  input logic [31:0] length);
        write_reg(REG_DELAY, delay);
        write_reg(REG_ALLPASS, allpass);
        write_reg(REG_GAIN, gain);
        write_reg(REG_LOWPASS, lowpass);
        write_reg(REG_LENGTH, length);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic play_random_note(input int note_no);
        int          d;
        int          n_eff;
        int          n_plucks;
        int          n_ticks;
        int          shape;
        logic [16:0] len;
        logic [15:0] gain;
        quiesce();
        case ($urandom_range(0, 19))
            0: d = 0;
            1: d = 4095;
            2, 3: d = $urandom_range(13, 60);
            default: d = $urandom_range(1, 12);
        endcase
        n_eff = (d == 0) ? 1 : d;
        case ($urandom_range(0, 9))
            0: len = 17'($urandom_range(0, 1));
            1: len = 17'd65536;
            2: len = 17'($urandom_range(65537, 131071));
            default: len = 17'($urandom_range(2, ((n_eff > 60) ? 60 : n_eff) + 40));
        endcase
        case ($urandom_range(0, 7))
            0: gain = '0;
            1: gain = 16'hFFFF;
            default: gain = 16'($urandom);
        endcase
        apply_settings({20'($urandom), 12'(d)}, {16'($urandom), coef_value()},
                       {16'($urandom), gain}, {16'($urandom), coef_value()},
                       {15'($urandom), len});
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
        shape = (note_no == 2) ? 3 : $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(5, 30)) send_item(1'($urandom), noise_value());
        end else begin
            if (n_eff > 60) n_plucks = $urandom_range(0, 20);
            else if (shape == 1) n_plucks = $urandom_range(0, n_eff);
            else if (shape == 2) n_plucks = n_eff + 1 + $urandom_range(1, 4);
            else n_plucks = n_eff + 1;
            n_ticks = $urandom_range(1, 80);
            if (note_no == 2) begin
                src_calm     = 1'b1;
                n_ticks      = 60;
                hold_request = HOLD_CYCLES;
            end
            repeat (n_plucks) send_item(OP_PLUCK, noise_value());
            repeat (n_ticks) send_item(OP_TICK, noise_value());
        end
    endtask

    initial begin : drain
        int wait_n;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            wait_n = snk_calm ? 0 : $urandom_range(0, 17);
            if (wait_n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            board.check_sample(out_ch.audio_sample, out_ch.play_index);
        end
    end

    initial begin : stimulus
        int note_no;
        board = new;
        board.power_on();
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_TICK;
        in_ch.noise_sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks on an empty note run the loop on zeros
        send_item(OP_TICK, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000);
        quiesce();

        // clamped delay, coefficient and length; full-scale noise; surplus pluck; wrap
        apply_settings(32'd0, 32'hFFFF, 32'hFFFF, 32'd0, 32'd1);
        send_item(OP_PLUCK, 16'sh7FFF);
        send_item(OP_PLUCK, 16'sh8000);
        send_item(OP_PLUCK, 16'sh0005);
        repeat (5) send_item(OP_TICK, noise_value());
        send_item(OP_PLUCK, 16'sh8000);
        quiesce();

        // short excitation continued by the string loop, saturating gain
        apply_settings(32'd3, 32'd0, 32'hFFFF, 32'h8001, 32'h1FFFF);
        send_item(OP_PLUCK, 16'sh7FFF);
        repeat (6) send_item(OP_TICK, noise_value());
        quiesce();

        // shrink the note below the play position
        apply_settings(32'd3, 32'd0, 32'hFFFF, 32'h8001, 32'd2);
        repeat (3) send_item(OP_TICK, noise_value());

        counted = 0;
        note_no = 0;
        while (counted < RANDOM_ITEMS) begin
            play_random_note(note_no);
            note_no++;
        end

        quiesce();
        if (board.errors == 0 && board.sample_queue.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/psv_pkg.sv
rtl/psv_in_if.sv
rtl/psv_out_if.sv
rtl/psv_ram.sv
rtl/psv_cfg.sv
rtl/plucked_string_voice.sv
verif/psv_tb_pkg.sv
verif/tb.sv
